@@ rtl/lzd_pkg.sv @@
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants for the LZ stream decompressor.
// Holds the input and result item structs, opcode codes and field constants.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int unsigned HistDepth = 262144;
  localparam int unsigned HistAw    = $clog2(HistDepth);

  localparam logic [1:0] OpByte    = 2'd0;
  localparam logic [1:0] OpAdvance = 2'd1;
  localparam logic [1:0] OpRestart = 2'd2;

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StDone = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  localparam logic [7:0] EndMark0 = 8'h05;
  localparam logic [7:0] EndMark1 = 8'hFA;
  localparam logic [7:0] Sig0     = 8'h57;
  localparam logic [7:0] Sig1     = 8'hBC;
  localparam logic [16:0] AdlerMod = 17'd65521;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       accepted;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Write/read request to the history memory.
  typedef struct packed {
    logic              wr_en;
    logic [HistAw-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [HistAw-1:0] rd_addr;
  } hist_req_t;

  // Operand bytes needed after an opcode; 7 marks an illegal opcode.
  function automatic logic [2:0] operands_needed(input logic [7:0] o);
    logic [2:0] n;
    if (o >= 8'h80)      n = 3'd1;
    else if (o >= 8'h40) n = 3'd2;
    else if (o >= 8'h20) n = 3'd0;
    else if (o >= 8'h18) n = 3'd3;
    else if (o >= 8'h10) n = 3'd4;
    else if (o >= 8'h08) n = 3'd1;
    else if (o == 8'h07) n = 3'd2;
    else if (o == 8'h06) n = 3'd4;
    else if (o == 8'h04) n = 3'd5;
    else                 n = 3'd7;
    return n;
  endfunction

endpackage

@@ rtl/lzd_history.sv @@
// ----------------------------------------------------------------------------
// lzd_history: history memory of decompressed bytes.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lzd_history (
  input  logic                clk,
  input  lzd_pkg::hist_req_t  req,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [lzd_pkg::HistDepth];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

@@ rtl/lzd_adler.sv @@
// ----------------------------------------------------------------------------
// lzd_adler: running Adler-32 of the output bytes.
// Each update folds one byte in with one compare and subtract per half.
// ----------------------------------------------------------------------------
module lzd_adler (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        update,
  input  logic [7:0]  data,
  output logic [31:0] sum
);

  logic [15:0] adler_low;
  logic [15:0] adler_high;
  logic [16:0] low_raw;
  logic [16:0] low_mod;
  logic [16:0] high_raw;
  logic [16:0] high_mod;

  always_comb begin
    low_raw  = {1'b0, adler_low} + {9'd0, data};
    low_mod  = (low_raw >= lzd_pkg::AdlerMod) ? low_raw - lzd_pkg::AdlerMod : low_raw;
    high_raw = {1'b0, adler_high} + low_mod;
    high_mod = (high_raw >= lzd_pkg::AdlerMod) ? high_raw - lzd_pkg::AdlerMod : high_raw;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      adler_low  <= 16'd1;
      adler_high <= 16'd0;
    end else if (update) begin
      adler_low  <= low_mod[15:0];
      adler_high <= high_mod[15:0];
    end
  end

  assign sum = {adler_high, adler_low};

endmodule

@@ rtl/lz_stream_decompressor.sv @@
// A result item is registered when its input item is accepted. An item that
// completes a token shows its result only after its range checks in tok_pending.
// Throughput: one item per cycle while results drain; input stalls while a completed token
// is checked. Match bytes are read from history and shown from the read register.
// Reset: rst clears all stream state; history content is undefined until written.
// ----------------------------------------------------------------------------
// lz_stream_decompressor: byte-serial LZ decoder with a history memory.
// Parses header, tokens, end marker and Adler-32 and emits one result item
// for every input item.
// ----------------------------------------------------------------------------
module lz_stream_decompressor (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lzd_pkg::out_item_t  out_data
);

  typedef enum logic [8:0] {
    PH_HEADER  = 9'b000000001,
    PH_OPCODE  = 9'b000000010,
    PH_OPERAND = 9'b000000100,
    PH_LITERAL = 9'b000001000,
    PH_MATCH   = 9'b000010000,
    PH_ENDMARK = 9'b000100000,
    PH_CHECK   = 9'b001000000,
    PH_DONE    = 9'b010000000,
    PH_ERROR   = 9'b100000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  header_index, header_index_next;
  logic [7:0]  opcode_byte, opcode_byte_next;
  logic [2:0]  operand_count, operand_count_next;
  logic [39:0] operand_bytes, operand_bytes_next;
  logic [16:0] literal_left, literal_left_next;
  logic [16:0] match_left, match_left_next;
  logic [23:0] match_distance, match_distance_next;
  logic [31:0] expected_length, expected_length_next;
  logic [31:0] produced_count;
  logic [31:0] checksum_word, checksum_word_next;

  // Output register stage; a match item keeps its byte in the memory read
  // register, selected by out_from_mem.
  logic        out_full;
  logic        out_from_mem;
  lzd_pkg::out_item_t out_reg, out_reg_next;
  logic [7:0]  hist_rd;

  // Token decode is registered: a completed token waits in tok_pending
  // for its range checks, with the block stalled while it waits.
  // The result item of the completing byte is held back until the checks are done.
  logic        tok_pending, tok_pending_next;
  logic        tok_is_lit;
  logic        tok_err;
  logic [16:0] tok_len;
  logic [24:0] tok_dist;

  logic        take;
  logic        emit, emit_from_mem;
  logic [7:0]  emit_byte;
  logic        ok, last_flag, acc;
  logic [31:0] adler_sum;
  logic        stream_clear;
  lzd_pkg::hist_req_t hreq;
  logic [2:0]  need;
  logic [39:0] ob;

  // Result register takes a new item when it is empty or being drained and no token is pending.
  assign in_ready  = (!out_full || out_ready) && !tok_pending;
  assign take      = in_valid && in_ready;
  assign out_valid = out_full && !tok_pending;

  always_comb begin
    out_data = out_reg;
    if (out_from_mem) begin
      out_data.out_byte = hist_rd;
    end
  end

  // Operand fields of a completed token.
  always_comb begin
    logic [7:0] o;
    o   = opcode_byte;
    ob  = operand_bytes;
    tok_is_lit = 1'b0;
    tok_len    = 17'd0;
    tok_dist   = 25'd1;
    if (o >= 8'h80) begin
      tok_len  = {10'd0, o[6:0]} + 17'd1;
      tok_dist = {17'd0, ob[7:0]} + 25'd1;
    end else if (o >= 8'h40) begin
      tok_dist = {11'd0, o[5:0], ob[15:8]} + 25'd1;
      tok_len  = {9'd0, ob[7:0]} + 17'd1;
    end else if (o >= 8'h20) begin
      tok_is_lit = 1'b1;
      tok_len    = {12'd0, o[4:0]} + 17'd1;
    end else if (o >= 8'h18) begin
      tok_dist = {6'd0, o[2:0], ob[23:8]} + 25'd1;
      tok_len  = {9'd0, ob[7:0]} + 17'd1;
    end else if (o >= 8'h10) begin
      tok_dist = {5'd0, o[3:0], ob[31:16]} + 25'd1;
      tok_len  = {1'b0, ob[15:0]} + 17'd1;
    end else if (o >= 8'h08) begin
      tok_is_lit = 1'b1;
      tok_len    = {6'd0, o[2:0], ob[7:0]} + 17'd1;
    end else if (o == 8'h07) begin
      tok_is_lit = 1'b1;
      tok_len    = {1'b0, ob[15:0]} + 17'd1;
    end else if (o == 8'h06) begin
      tok_dist = {1'b0, ob[31:8]} + 25'd1;
      tok_len  = {9'd0, ob[7:0]} + 17'd1;
    end else begin
      tok_dist = {1'b0, ob[39:16]} + 25'd1;
      tok_len  = {1'b0, ob[15:0]} + 17'd1;
    end
  end

  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    opcode_byte_next     = opcode_byte;
    operand_count_next   = operand_count;
    operand_bytes_next   = operand_bytes;
    literal_left_next    = literal_left;
    match_left_next      = match_left;
    match_distance_next  = match_distance;
    expected_length_next = expected_length;
    checksum_word_next   = checksum_word;
    tok_pending_next     = 1'b0;
    tok_err       = 1'b0;
    emit          = 1'b0;
    emit_from_mem = 1'b0;
    emit_byte     = 8'd0;
    ok            = 1'b1;
    last_flag     = 1'b0;
    acc           = 1'b0;
    stream_clear  = 1'b0;
    need          = lzd_pkg::operands_needed(in_data.data_byte);
    hreq          = '0;

    if (tok_pending) begin
      // Range checks for the token decoded last cycle; no item is taken.
      if ({1'b0, produced_count} + {16'd0, tok_len} > {1'b0, expected_length}) begin
        phase_next = PH_ERROR;
        tok_err    = 1'b1;
      end else if (tok_is_lit) begin
        literal_left_next = tok_len;
        phase_next        = PH_LITERAL;
      end else if ({7'd0, tok_dist} > produced_count ||
                   tok_dist > 25'(lzd_pkg::HistDepth)) begin
        phase_next = PH_ERROR;
        tok_err    = 1'b1;
      end else begin
        match_left_next     = tok_len;
        match_distance_next = 24'(tok_dist - 25'd1);
        phase_next          = PH_MATCH;
      end
    end else if (take) begin
      if (in_data.op == lzd_pkg::OpRestart) begin
        stream_clear         = 1'b1;
        phase_next           = PH_HEADER;
        header_index_next    = '0;
        opcode_byte_next     = '0;
        operand_count_next   = '0;
        operand_bytes_next   = '0;
        literal_left_next    = '0;
        match_left_next      = '0;
        match_distance_next  = '0;
        expected_length_next = '0;
        checksum_word_next   = '0;
      end else if (in_data.op == lzd_pkg::OpAdvance) begin
        if (phase == PH_MATCH) begin
          emit          = 1'b1;
          emit_from_mem = 1'b1;
          hreq.rd_en    = 1'b1;
          hreq.rd_addr  = lzd_pkg::HistAw'(produced_count - {8'd0, match_distance} - 32'd1);
          match_left_next = match_left - 17'd1;
          if (match_left == 17'd1) begin
            phase_next = PH_OPCODE;
          end
        end
      end else if (in_data.op == lzd_pkg::OpByte && phase != PH_MATCH &&
                   phase != PH_DONE && phase != PH_ERROR) begin
        acc = 1'b1;
        unique case (phase)
          PH_HEADER: begin
            if (header_index == 4'd0) begin
              ok = (in_data.data_byte == lzd_pkg::Sig0);
            end else if (header_index == 4'd1) begin
              ok = (in_data.data_byte == lzd_pkg::Sig1);
            end else if (header_index < 4'd8) begin
              ok = (in_data.data_byte == 8'd0);
            end else if (header_index < 4'd12) begin
              expected_length_next = {expected_length[23:0], in_data.data_byte};
            end
            if (header_index == 4'd15) begin
              phase_next        = PH_OPCODE;
              header_index_next = '0;
            end else begin
              header_index_next = header_index + 4'd1;
            end
          end
          PH_OPCODE: begin
            opcode_byte_next   = in_data.data_byte;
            operand_bytes_next = '0;
            if (in_data.data_byte == lzd_pkg::EndMark0) begin
              phase_next = PH_ENDMARK;
            end else if (need == 3'd7) begin
              ok = 1'b0;
            end else if (need == 3'd0) begin
              tok_pending_next = 1'b1;
            end else begin
              operand_count_next = need;
              phase_next         = PH_OPERAND;
            end
          end
          PH_OPERAND: begin
            operand_bytes_next = {operand_bytes[31:0], in_data.data_byte};
            operand_count_next = operand_count - 3'd1;
            if (operand_count == 3'd1) begin
              tok_pending_next = 1'b1;
            end
          end
          PH_LITERAL: begin
            emit      = 1'b1;
            emit_byte = in_data.data_byte;
            literal_left_next = literal_left - 17'd1;
            if (literal_left == 17'd1) begin
              phase_next = PH_OPCODE;
            end
          end
          PH_ENDMARK: begin
            if (in_data.data_byte != lzd_pkg::EndMark1 || produced_count != expected_length) begin
              ok = 1'b0;
            end else begin
              phase_next         = PH_CHECK;
              operand_count_next = '0;
              checksum_word_next = '0;
            end
          end
          PH_CHECK: begin
            checksum_word_next = {checksum_word[23:0], in_data.data_byte};
            operand_count_next = operand_count + 3'd1;
            if (operand_count == 3'd3) begin
              if ({checksum_word[23:0], in_data.data_byte} == adler_sum) begin
                phase_next = PH_DONE;
                last_flag  = 1'b1;
              end else begin
                ok = 1'b0;
              end
            end
          end
          default: begin
            ok = 1'b1;
          end
        endcase
        if (!ok) begin
          phase_next = PH_ERROR;
          last_flag  = 1'b1;
        end
      end
    end

    if (emit && !emit_from_mem) begin
      hreq.wr_en   = 1'b1;
      hreq.wr_addr = lzd_pkg::HistAw'(produced_count);
      hreq.wr_data = emit_byte;
    end

    out_reg_next.out_valid = emit;
    out_reg_next.out_byte  = emit_byte;
    out_reg_next.accepted  = acc;
    out_reg_next.last      = last_flag;
    out_reg_next.status    = (phase_next == PH_DONE)  ? lzd_pkg::StDone :
                             (phase_next == PH_ERROR) ? lzd_pkg::StErr : lzd_pkg::StRun;
  end

  // A copied byte is written back in the cycle after its read, from the read
  // register. The next read can need that byte; it is then forwarded.
  logic        wb_pending;
  logic [lzd_pkg::HistAw-1:0] wb_addr;
  lzd_pkg::hist_req_t hreq_mem;

  always_comb begin
    hreq_mem = hreq;
    if (wb_pending) begin
      hreq_mem.wr_en   = 1'b1;
      hreq_mem.wr_addr = wb_addr;
      hreq_mem.wr_data = hist_rd;
    end
  end

  // A copy at distance one reads the byte still waiting for write-back.
  logic fwd_sel;
  logic [7:0] fwd_byte;
  logic [7:0] mem_q;

  lzd_history u_history (
    .clk     (clk),
    .req     (hreq_mem),
    .rd_data (mem_q)
  );

  assign hist_rd = fwd_sel ? fwd_byte : mem_q;

  always_ff @(posedge clk) begin
    fwd_byte <= hist_rd;
    if (rst) begin
      fwd_sel <= 1'b0;
    end else if (hreq.rd_en) begin
      fwd_sel <= wb_pending && (hreq.rd_addr == wb_addr);
    end
  end

  lzd_adler u_adler (
    .clk    (clk),
    .rst    (rst),
    .clear  (stream_clear),
    .update (wb_pending || (emit && !emit_from_mem)),
    .data   (wb_pending ? hist_rd : emit_byte),
    .sum    (adler_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_index    <= '0;
      opcode_byte     <= '0;
      operand_count   <= '0;
      operand_bytes   <= '0;
      literal_left    <= '0;
      match_left      <= '0;
      match_distance  <= '0;
      expected_length <= '0;
      produced_count  <= '0;
      checksum_word   <= '0;
      tok_pending     <= 1'b0;
      out_full        <= 1'b0;
      out_from_mem    <= 1'b0;
      wb_pending      <= 1'b0;
    end else begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      opcode_byte     <= opcode_byte_next;
      operand_count   <= operand_count_next;
      operand_bytes   <= operand_bytes_next;
      literal_left    <= literal_left_next;
      match_left      <= match_left_next;
      match_distance  <= match_distance_next;
      expected_length <= expected_length_next;
      checksum_word   <= checksum_word_next;
      tok_pending     <= tok_pending_next;
      wb_pending      <= emit_from_mem;
      if (stream_clear) begin
        produced_count <= '0;
      end else if (emit) begin
        produced_count <= produced_count + 32'd1;
      end
      if (take) begin
        out_full     <= 1'b1;
        out_from_mem <= emit_from_mem;
      end else if (out_valid && out_ready) begin
        out_full     <= 1'b0;
      end
    end
  end

  // The result of a byte that completes a token takes its status and last
  // flag from the range checks in the following cycle. A stalled match result
  // keeps its byte because the read register only changes when an item is taken.
  always_ff @(posedge clk) begin
    wb_addr <= hreq.rd_en ? lzd_pkg::HistAw'(produced_count) : wb_addr;
    if (take) begin
      out_reg <= out_reg_next;
    end else if (tok_pending) begin
      out_reg.status <= out_reg_next.status;
      out_reg.last   <= tok_err;
    end
  end

`ifndef SYNTHESIS
  a_tok_stall: assert property (@(posedge clk) disable iff (rst)
    tok_pending |-> !in_ready) else $error("item taken during token check");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_emit_phase: assert property (@(posedge clk) disable iff (rst)
    emit_from_mem |-> $past(phase_next == PH_MATCH || phase_next == PH_OPCODE) ||
    phase == PH_MATCH) else $error("copy outside match");
`endif

endmodule
